// ===== rtl/core/pump_time_proportion_drive_assert.svh =====
// Assertion macros for the pump drive.
`ifndef PUMP_TIME_PROPORTION_DRIVE_ASSERT_SVH
`define PUMP_TIME_PROPORTION_DRIVE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property at each rising edge, quiet while reset is asserted.
`define PTPD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pump drive assertion failed");
// Check a property at each rising edge, reset included.
`define PTPD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pump drive assertion failed");
`else
`define PTPD_ASSERT(label, clk, rst_n, prop)
`define PTPD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/core/ptpd_pkg.sv =====
`timescale 1ns / 1ps

package ptpd_pkg;

    localparam int RATE_W   = 16;
    localparam int MS_W     = 16;
    localparam int FULL_W   = 24;
    localparam int PROD_W   = MS_W + RATE_W;
    localparam int VOL_W    = 48;
    localparam int SEC_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 24;
    localparam int VOL_SLOTS = 4;

    localparam logic [MS_W-1:0]  MIN_ON_MS        = 16'd50;
    localparam logic [SEC_W-1:0] TICKS_PER_UPDATE = 10'd1000;
    localparam logic [MS_W-1:0]  ELAPSED_SAT      = '1;

    // actions
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_ENABLE  = 2'd1;
    localparam logic [1:0] ACT_DISABLE = 2'd2;
    localparam logic [1:0] ACT_CLEAR   = 2'd3;

    // process modes
    localparam logic [1:0] MODE_RECT    = 2'd0;
    localparam logic [1:0] MODE_DISTILL = 2'd1;

    // rectification phases / volume slots
    localparam logic [1:0] PHASE_OTHER  = 2'd3;
    localparam logic [1:0] SLOT_DISTILL = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_RATE = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [RATE_W-1:0] flow_rate;
        logic              running;
        logic [1:0]        process_mode;
        logic [1:0]        phase;
    } cmd_t;

    typedef struct packed {
        logic              pump_drive;
        logic              pump_enabled;
        logic [RATE_W-1:0] rate_now;
        logic [MS_W-1:0]   on_time_ms;
        logic [VOL_W-1:0]  heads_volume;
        logic [VOL_W-1:0]  body_volume;
        logic [VOL_W-1:0]  tails_volume;
        logic [VOL_W-1:0]  distill_volume;
    } rsp_t;

endpackage

// ===== rtl/core/pump_time_proportion_drive.sv =====
// Sequence: a tick, disable or clear beat, or an enable below the minimum rate, goes from
// idle straight to the emit state, which loads its result beat; an enable with zero calibration
// first passes multiply and finish, any other enable multiply, 32 restoring steps on one subtractor and finish.
// A stalled earlier result holds the emit state before the load.
// Input stalls from acceptance until the load, so a new beat is taken only once the last is through.
// Reset: asynchronous, clears control, volumes and config to defaults; no sweep.
`timescale 1ns / 1ps

`include "pump_time_proportion_drive_assert.svh"

module pump_time_proportion_drive (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [ptpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptpd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  ptpd_pkg::cmd_t                 cmd,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output ptpd_pkg::rsp_t                 rsp
);
    import ptpd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [RATE_W-1:0] min_rate_reg, min_rate_next;
    logic [RATE_W-1:0] max_rate_reg, max_rate_next;
    logic [MS_W-1:0]   period_reg, period_next;
    logic [FULL_W-1:0] full_reg, full_next;

    logic              drive_reg, drive_next;
    logic              enabled_reg, enabled_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [MS_W-1:0]   on_reg, on_next;
    logic [MS_W-1:0]   elapsed_reg, elapsed_next;
    logic [SEC_W-1:0]  sec_reg, sec_next;
    logic [VOL_W-1:0]  vol_reg [VOL_SLOTS];
    logic [VOL_W-1:0]  vol_next [VOL_SLOTS];

    logic [RATE_W-1:0] work_rate_reg, work_rate_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [FULL_W-1:0] rem_reg, rem_next;
    logic [4:0]        step_reg, step_next;

    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              cmd_take;
    logic [MS_W-1:0]   elapsed_inc;
    logic              restart;
    logic [MS_W-1:0]   elapsed_tick;
    logic              drive_tick;
    logic [SEC_W:0]    sec_inc;
    logic              sec_wrap;
    logic              credit;
    logic [1:0]        slot;
    logic [VOL_W:0]    vol_sum;
    logic [VOL_W-1:0]  vol_sat;
    logic [RATE_W-1:0] req_clamped;
    logic [FULL_W:0]   rem_shift;
    logic              fits;
    logic [FULL_W:0]   rem_diff;
    logic [MS_W-1:0]   on_cap;
    logic [MS_W-1:0]   on_fin;

    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // tick datapath
    always_comb
    begin
        elapsed_inc  = (elapsed_reg == ELAPSED_SAT) ? elapsed_reg : elapsed_reg + 1'b1;
        restart      = (elapsed_inc >= period_reg);
        elapsed_tick = restart ? '0 : elapsed_inc;
        drive_tick   = (restart && (on_reg != '0)) ? 1'b1 : drive_reg;
        if ((on_reg == '0) || (elapsed_tick >= on_reg))
        begin
            drive_tick = 1'b0;
        end
        sec_inc  = {1'b0, sec_reg} + 1'b1;
        sec_wrap = (sec_inc >= {1'b0, TICKS_PER_UPDATE});
        slot     = cmd.phase;
        credit   = 1'b0;
        if (cmd.running)
        begin
            if (cmd.process_mode == MODE_RECT)
            begin
                credit = (cmd.phase != PHASE_OTHER);
            end
            else if (cmd.process_mode == MODE_DISTILL)
            begin
                credit = 1'b1;
                slot   = SLOT_DISTILL;
            end
        end
        vol_sum = {1'b0, vol_reg[slot]} + {{(VOL_W+1-RATE_W){1'b0}}, rate_reg};
        vol_sat = vol_sum[VOL_W] ? '1 : vol_sum[VOL_W-1:0];
    end

    // enable datapath: clamp, one divide step, finish
    always_comb
    begin
        req_clamped = (cmd.flow_rate > max_rate_reg) ? max_rate_reg : cmd.flow_rate;
        rem_shift   = {rem_reg, quo_reg[PROD_W-1]};
        fits        = (rem_shift >= {1'b0, full_reg});
        rem_diff    = rem_shift - {1'b0, full_reg};
        on_cap      = (quo_reg > {{(PROD_W-MS_W){1'b0}}, period_reg}) ?
                      period_reg : quo_reg[MS_W-1:0];
        on_fin      = ((on_cap != '0) && (on_cap < MIN_ON_MS)) ? MIN_ON_MS : on_cap;
    end

    always_comb
    begin
        state_next     = state_reg;
        min_rate_next  = min_rate_reg;
        max_rate_next  = max_rate_reg;
        period_next    = period_reg;
        full_next      = full_reg;
        drive_next     = drive_reg;
        enabled_next   = enabled_reg;
        rate_next      = rate_reg;
        on_next        = on_reg;
        elapsed_next   = elapsed_reg;
        sec_next       = sec_reg;
        vol_next       = vol_reg;
        work_rate_next = work_rate_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_MIN_RATE:  min_rate_next = cfg_data[RATE_W-1:0];
                REG_MAX_RATE:  max_rate_next = cfg_data[RATE_W-1:0];
                REG_PERIOD:    period_next   = cfg_data[MS_W-1:0];
                REG_FULL_RATE: full_next     = cfg_data[FULL_W-1:0];
            endcase
        end

        // drop the result beat once taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    state_next = S_EMIT;
                    unique case (cmd.action)
                        ACT_TICK:
                        begin
                            if (!enabled_reg)
                            begin
                                elapsed_next = elapsed_inc;
                                drive_next   = 1'b0;
                            end
                            else
                            begin
                                elapsed_next = elapsed_tick;
                                drive_next   = drive_tick;
                                sec_next     = sec_wrap ? '0 : sec_inc[SEC_W-1:0];
                                if (sec_wrap && credit)
                                begin
                                    vol_next[slot] = vol_sat;
                                end
                            end
                        end
                        ACT_ENABLE:
                        begin
                            if (cmd.flow_rate < min_rate_reg)
                            begin
                                drive_next   = 1'b0;
                                enabled_next = 1'b0;
                                rate_next    = '0;
                                on_next      = '0;
                            end
                            else
                            begin
                                work_rate_next = req_clamped;
                                state_next     = S_MUL;
                            end
                        end
                        ACT_DISABLE:
                        begin
                            drive_next   = 1'b0;
                            enabled_next = 1'b0;
                            rate_next    = '0;
                            on_next      = '0;
                        end
                        ACT_CLEAR:
                        begin
                            for (int i = 0; i < VOL_SLOTS; i++)
                            begin
                                vol_next[i] = '0;
                            end
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                rem_next  = '0;
                step_next = '0;
                if (full_reg == '0)
                begin
                    // no calibration: treat as full duty
                    quo_next   = (work_rate_reg != '0) ?
                                 {{(PROD_W-MS_W){1'b0}}, period_reg} : '0;
                    state_next = S_FIN;
                end
                else
                begin
                    quo_next   = period_reg * work_rate_reg;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                quo_next  = {quo_reg[PROD_W-2:0], fits};
                rem_next  = fits ? rem_diff[FULL_W-1:0] : rem_shift[FULL_W-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == 5'(PROD_W - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                rate_next    = work_rate_reg;
                on_next      = on_fin;
                enabled_next = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output slot is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.pump_drive     = drive_reg;
                    rsp_next.pump_enabled   = enabled_reg;
                    rsp_next.rate_now       = rate_reg;
                    rsp_next.on_time_ms     = on_reg;
                    rsp_next.heads_volume   = vol_reg[0];
                    rsp_next.body_volume    = vol_reg[1];
                    rsp_next.tails_volume   = vol_reg[2];
                    rsp_next.distill_volume = vol_reg[3];
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_rate_reg  <= 16'd0;
            max_rate_reg  <= 16'd2000;
            period_reg    <= 16'd10000;
            full_reg      <= 24'd3600;
            drive_reg     <= 1'b0;
            enabled_reg   <= 1'b0;
            rate_reg      <= '0;
            on_reg        <= '0;
            elapsed_reg   <= ELAPSED_SAT;
            sec_reg       <= '0;
            for (int i = 0; i < VOL_SLOTS; i++)
            begin
                vol_reg[i] <= '0;
            end
            work_rate_reg <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            min_rate_reg  <= min_rate_next;
            max_rate_reg  <= max_rate_next;
            period_reg    <= period_next;
            full_reg      <= full_next;
            drive_reg     <= drive_next;
            enabled_reg   <= enabled_next;
            rate_reg      <= rate_next;
            on_reg        <= on_next;
            elapsed_reg   <= elapsed_next;
            sec_reg       <= sec_next;
            vol_reg       <= vol_next;
            work_rate_reg <= work_rate_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    `PTPD_ASSERT(a_drive_needs_enable, clk, rst_n, drive_reg |-> enabled_reg)
    `PTPD_ASSERT(a_off_clears_rate, clk, rst_n, !enabled_reg |-> (rate_reg == '0 && on_reg == '0))
    `PTPD_ASSERT(a_on_time_floor, clk, rst_n, (on_reg != '0) |-> (on_reg >= MIN_ON_MS))
    `PTPD_ASSERT(a_sec_range, clk, rst_n, sec_reg < TICKS_PER_UPDATE)
    `PTPD_ASSERT(a_div_ends, clk, rst_n, (state_reg == S_DIV && step_reg == 5'(PROD_W - 1)) |=> (state_reg == S_FIN))

endmodule
